### rtl/lpt_pkg.sv
// ----------------------------------------------------------------------------
// lpt_pkg
// Shared types and constants of the IPv4 longest-prefix table: table size,
// item codes, result status codes and the records passed along the cell chain.
// ----------------------------------------------------------------------------
package lpt_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

   localparam int FAMILY_W   = 24;
   localparam int SUBPROTO_W = 8;
   localparam int ADDR_W     = 32;
   localparam int PREFIX_W   = 6;
   localparam int PORT_W     = 16;
   localparam int HANDLE_W   = 16;
   localparam int STATUS_W   = 2;
   localparam int SLOT_W     = 6;

   localparam logic [PREFIX_W-1:0]   MAX_PREFIX    = 6'd32;
   localparam logic [SUBPROTO_W-1:0] SUBPROTO_WILD = 8'd0;

   localparam logic FUNC_BIND   = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [COUNT_W-1:0] count_type;

   typedef struct packed {
      logic                  func;
      logic [FAMILY_W-1:0]   family;
      logic [SUBPROTO_W-1:0] subproto;
      logic [ADDR_W-1:0]     address;
      logic [PREFIX_W-1:0]   prefix_len;
      logic [PORT_W-1:0]     port;
      logic [HANDLE_W-1:0]   handle;
   } query_type;

   // Search token: the query plus the best match seen so far.
   typedef struct packed {
      logic                valid;
      logic                fam_ok;
      query_type           query;
      logic                match;
      idx_type             idx;
      logic [PREFIX_W-1:0] prefix;
      logic [HANDLE_W-1:0] handle;
   } token_type;

   // Table update broadcast to every cell.
   typedef struct packed {
      logic      en;
      logic      append;
      idx_type   idx;
      query_type query;
   } write_type;

endpackage

### rtl/lpt_cell.sv
// ----------------------------------------------------------------------------
// lpt_cell
// One table entry. Compares the passing search token against the entry,
// updates the best match and hands the token to the next cell.
// ----------------------------------------------------------------------------
module lpt_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  lpt_pkg::idx_type     cell_index,
   input  lpt_pkg::token_type   tok_in,
   output lpt_pkg::token_type   tok_out,
   input  lpt_pkg::write_type   wr
);

   logic                                  valid_ff;
   logic [lpt_pkg::FAMILY_W-1:0]          family_ff;
   logic [lpt_pkg::SUBPROTO_W-1:0]        subproto_ff;
   logic [lpt_pkg::ADDR_W-1:0]            address_ff;
   logic [lpt_pkg::PREFIX_W-1:0]          prefix_ff;
   logic [lpt_pkg::PORT_W-1:0]            port_ff;
   logic [lpt_pkg::HANDLE_W-1:0]          handle_ff;

   lpt_pkg::token_type                    tok_ff;
   lpt_pkg::token_type                    tok_in_next;

   logic [lpt_pkg::PREFIX_W-1:0]          eff_prefix;
   logic [lpt_pkg::ADDR_W-1:0]            mask;
   logic                                  exact_hit;
   logic                                  prefix_hit;
   logic                                  take;
   logic                                  wr_here;

   assign eff_prefix = (prefix_ff > lpt_pkg::MAX_PREFIX) ? lpt_pkg::MAX_PREFIX : prefix_ff;
   // Length 0 gives an empty mask; a shift by the full width leaves zero, so
   // length 32 gives a full one.
   assign mask = ~({lpt_pkg::ADDR_W{1'b1}} >> eff_prefix);

   always_comb begin
      exact_hit = valid_ff && tok_in.fam_ok &&
                  family_ff == tok_in.query.family &&
                  subproto_ff == tok_in.query.subproto &&
                  port_ff == tok_in.query.port &&
                  address_ff == tok_in.query.address;
      prefix_hit = valid_ff && tok_in.fam_ok &&
                   family_ff == tok_in.query.family &&
                   (subproto_ff == lpt_pkg::SUBPROTO_WILD ||
                    subproto_ff == tok_in.query.subproto) &&
                   (tok_in.query.address & mask) == (address_ff & mask);
      // Later cells are newer, so equal prefixes replace the earlier best.
      if (tok_in.query.func == lpt_pkg::FUNC_LOOKUP) begin
         take = prefix_hit && (!tok_in.match || eff_prefix >= tok_in.prefix);
      end else begin
         take = exact_hit;
      end
      tok_in_next = tok_in;
      if (take) begin
         tok_in_next.match  = 1'b1;
         tok_in_next.idx    = cell_index;
         tok_in_next.prefix = (tok_in.query.func == lpt_pkg::FUNC_LOOKUP) ? eff_prefix
                                                                          : prefix_ff;
         tok_in_next.handle = handle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in_next;
      end
   end

   assign wr_here = wr.en && wr.idx == cell_index;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (wr_here && wr.append) begin
         valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_here) begin
         handle_ff <= wr.query.handle;
         if (wr.append) begin
            family_ff   <= wr.query.family;
            subproto_ff <= wr.query.subproto;
            address_ff  <= wr.query.address;
            prefix_ff   <= wr.query.prefix_len;
            port_ff     <= wr.query.port;
         end
      end
   end

   assign tok_out = tok_ff;

endmodule

### rtl/ipv4_longest_prefix_table.sv
// ----------------------------------------------------------------------------
// ipv4_longest_prefix_table
// Address table with exact-match bind and IPv4 longest-prefix lookup.
// ----------------------------------------------------------------------------
// Each table entry lives in its own cell; the cells form a chain that a search
// token walks one cell per clock, carrying the best match so far. An item is
// accepted only while the block is idle. Its token passes through the cell
// chain, the chain output is captured, and then the table is updated and the
// result register loaded. That last step waits while an earlier result is
// still held by the receiver. The table is empty right after reset, with no
// clearing pass.
module ipv4_longest_prefix_table (
   input  logic          clock,
   input  logic          reset,

   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [23:0]   csr_data,      // ipv4_family

   input  logic          req_tvalid,
   output logic          req_tready,
   // tdata, low to high: family[23:0], subproto[31:24], address[63:32],
   // prefix_len[69:64], port[85:70], handle[101:86], zero[103:102]
   input  logic [103:0]  req_tdata,
   input  logic [0:0]    req_tuser,     // func

   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // tdata, low to high: slot[5:0], found_handle[21:6], found_prefix[27:22],
   // zero[31:28]
   output logic [31:0]   rsp_tdata,
   output logic [1:0]    rsp_tuser      // status
);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SEARCH = 3'b010,
      S_DONE   = 3'b100
   } state_type;

   state_type                             state_ff, state_in;
   logic [lpt_pkg::FAMILY_W-1:0]          ipv4_family_ff;
   lpt_pkg::count_type                    count_ff, count_in;
   lpt_pkg::token_type                    result_ff;

   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [lpt_pkg::STATUS_W-1:0]          status_ff, status_in;
   logic [lpt_pkg::SLOT_W-1:0]            slot_ff, slot_in;
   logic [lpt_pkg::HANDLE_W-1:0]          fhandle_ff, fhandle_in;
   logic [lpt_pkg::PREFIX_W-1:0]          fprefix_ff, fprefix_in;

   lpt_pkg::token_type                    head_tok;
   lpt_pkg::token_type                    tok [lpt_pkg::TABLE_DEPTH+1];
   lpt_pkg::write_type                    wr;
   logic                                  req_accept;
   logic                                  finish;
   logic                                  full;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ipv4_family_ff <= lpt_pkg::FAMILY_W'(1);
      end else if (csr_valid && csr_ready) begin
         ipv4_family_ff <= csr_data;
      end
   end

   always_comb begin
      head_tok                  = '0;
      head_tok.valid            = req_accept;
      head_tok.query.func       = req_tuser[0];
      head_tok.query.family     = req_tdata[23:0];
      head_tok.query.subproto   = req_tdata[31:24];
      head_tok.query.address    = req_tdata[63:32];
      head_tok.query.prefix_len = req_tdata[69:64];
      head_tok.query.port       = req_tdata[85:70];
      head_tok.query.handle     = req_tdata[101:86];
      head_tok.fam_ok           = (req_tdata[23:0] == ipv4_family_ff);
   end

   assign tok[0] = head_tok;

   for (genvar k = 0; k < lpt_pkg::TABLE_DEPTH; k++) begin : g_cell
      lpt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (lpt_pkg::idx_type'(k)),
         .tok_in     (tok[k]),
         .tok_out    (tok[k+1]),
         .wr         (wr)
      );
   end

   always_ff @(posedge clock) begin
      if (tok[lpt_pkg::TABLE_DEPTH].valid) begin
         result_ff <= tok[lpt_pkg::TABLE_DEPTH];
      end
   end

   assign full   = (count_ff >= lpt_pkg::count_type'(lpt_pkg::TABLE_DEPTH));
   assign finish = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      slot_in      = slot_ff;
      fhandle_in   = fhandle_ff;
      fprefix_in   = fprefix_ff;
      wr           = '0;
      wr.query     = result_ff.query;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (tok[lpt_pkg::TABLE_DEPTH].valid) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (finish) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               if (result_ff.query.func == lpt_pkg::FUNC_LOOKUP) begin
                  if (result_ff.match) begin
                     status_in  = lpt_pkg::STATUS_OK;
                     slot_in    = lpt_pkg::SLOT_W'(result_ff.idx);
                     fhandle_in = result_ff.handle;
                     fprefix_in = result_ff.prefix;
                  end else begin
                     status_in  = lpt_pkg::STATUS_MISS;
                     slot_in    = '0;
                     fhandle_in = '0;
                     fprefix_in = '0;
                  end
               end else if (result_ff.match) begin
                  // Rebind: replace the handle, keep the stored prefix.
                  wr.en      = 1'b1;
                  wr.idx     = result_ff.idx;
                  status_in  = lpt_pkg::STATUS_OK;
                  slot_in    = lpt_pkg::SLOT_W'(result_ff.idx);
                  fhandle_in = result_ff.query.handle;
                  fprefix_in = result_ff.prefix;
               end else if (full) begin
                  status_in  = lpt_pkg::STATUS_FULL;
                  slot_in    = '0;
                  fhandle_in = '0;
                  fprefix_in = '0;
               end else begin
                  wr.en      = 1'b1;
                  wr.append  = 1'b1;
                  wr.idx     = count_ff[lpt_pkg::IDX_W-1:0];
                  count_in   = count_ff + lpt_pkg::count_type'(1);
                  status_in  = lpt_pkg::STATUS_OK;
                  slot_in    = lpt_pkg::SLOT_W'(count_ff);
                  fhandle_in = result_ff.query.handle;
                  fprefix_in = result_ff.query.prefix_len;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      slot_ff    <= slot_in;
      fhandle_ff <= fhandle_in;
      fprefix_ff <= fprefix_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, fprefix_ff, fhandle_ff, slot_ff};
   assign rsp_tuser  = status_ff;

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ipv4_longest_prefix_table. Items are driven in
// random bursts and results are consumed under a changing stall pattern. A
// local copy of the table predicts every result: exact-match bind, IPv4
// longest-prefix lookup, wildcard sub-protocol and the table-full case. The
// IPv4 family code is rewritten between phases.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import lpt_pkg::*;

   localparam logic [FAMILY_W-1:0] FAMILY_RESET = 24'd1;
   localparam int SETTLE_CYCLES = TABLE_DEPTH + 40;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [HANDLE_W-1:0] handle;
      logic [PREFIX_W-1:0] prefix;
   } table_reply_t;

   typedef enum {STALL_NONE, STALL_SOME, STALL_HEAVY} stall_mode_t;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic [23:0]   csr_data = '0;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [103:0]  req_tdata = '0;
   logic [0:0]    req_tuser = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [31:0]   rsp_tdata;
   logic [1:0]    rsp_tuser;

   // stimulus side
   query_type             route_items [$];
   query_type             bound_keys [$];
   logic [FAMILY_W-1:0]   gen_family = FAMILY_RESET;
   int                    burst_left = 0;
   int                    gap_left = 0;

   // predicted table
   logic                  tbl_valid [TABLE_DEPTH];
   query_type             tbl_entry [TABLE_DEPTH];
   int                    tbl_count = 0;
   logic [FAMILY_W-1:0]   model_family = FAMILY_RESET;
   table_reply_t          table_replies_due [$];
   int                    error_count = 0;

   // receiver
   stall_mode_t           stall_mode = STALL_NONE;
   int                    mode_left = 0;
   int                    long_hold = 0;
   int                    rx_cycles = 0;

   ipv4_longest_prefix_table i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bind updates or appends an entry; lookup returns the longest matching
   // prefix, newest entry first on ties.
   function automatic table_reply_t bind_or_lookup(query_type q);
      table_reply_t        r;
      logic                have;
      int                  best;
      int                  best_len;
      int                  len;
      logic [ADDR_W-1:0]   mask;
      r = '0;
      have = 1'b0;
      best = 0;
      best_len = 0;
      if (q.func == FUNC_BIND) begin
         if (q.family == model_family) begin
            for (int k = tbl_count - 1; k >= 0; k--) begin
               if (tbl_valid[k] && tbl_entry[k].family == q.family &&
                   tbl_entry[k].subproto == q.subproto && tbl_entry[k].port == q.port &&
                   tbl_entry[k].address == q.address) begin
                  tbl_entry[k].handle = q.handle;
                  r = '{STATUS_OK, SLOT_W'(k), q.handle, tbl_entry[k].prefix_len};
                  return r;
               end
            end
         end
         if (tbl_count >= TABLE_DEPTH) begin
            r.status = STATUS_FULL;
         end else begin
            tbl_valid[tbl_count] = 1'b1;
            tbl_entry[tbl_count] = q;
            r = '{STATUS_OK, SLOT_W'(tbl_count), q.handle, q.prefix_len};
            tbl_count++;
         end
      end else begin
         if (q.family == model_family) begin
            for (int k = tbl_count - 1; k >= 0; k--) begin
               if (!tbl_valid[k] || tbl_entry[k].family != q.family) continue;
               if (tbl_entry[k].subproto != SUBPROTO_WILD &&
                   tbl_entry[k].subproto != q.subproto) continue;
               len = (tbl_entry[k].prefix_len > MAX_PREFIX) ? int'(MAX_PREFIX)
                                                             : int'(tbl_entry[k].prefix_len);
               // a zero-length prefix shifts the mask out completely
               mask = {ADDR_W{1'b1}} << (ADDR_W - len);
               if (((q.address ^ tbl_entry[k].address) & mask) != '0) continue;
               if (!have || len > best_len) begin
                  have = 1'b1;
                  best = k;
                  best_len = len;
               end
            end
         end
         if (have)
            r = '{STATUS_OK, SLOT_W'(best), tbl_entry[best].handle, PREFIX_W'(best_len)};
         else
            r.status = STATUS_MISS;
      end
      return r;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
   endfunction

   function automatic void push_item(query_type q);
      route_items.push_back(q);
      if (q.func == FUNC_BIND) bound_keys.push_back(q);
   endfunction

   // Mostly rebinds and lookups near known entries, with some fresh keys
   // and foreign families mixed in.
   function automatic query_type random_item();
      query_type      q;
      query_type      key;
      logic           have_key;
      int             ep;
      int             flip;
      q = '0;
      key = '0;
      have_key = 1'b0;
      for (int t = 0; t < 8 && !have_key && bound_keys.size() > 0; t++) begin
         key = bound_keys[$urandom_range(0, bound_keys.size() - 1)];
         have_key = (key.family == gen_family);
      end
      q.handle = 16'($urandom);
      q.port = 16'($urandom);
      if ($urandom_range(0, 9) < 4) begin
         q.func = FUNC_BIND;
         q.prefix_len = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(33, 63))
                                                    : 6'($urandom_range(0, 32));
         if (have_key && $urandom_range(0, 9) < 8) begin
            q.family = key.family;
            q.subproto = key.subproto;
            q.port = key.port;
            q.address = key.address;
         end else begin
            q.family = ($urandom_range(0, 19) == 0) ? 24'($urandom) : gen_family;
            q.subproto = ($urandom_range(0, 3) == 0) ? SUBPROTO_WILD : 8'($urandom);
            if (have_key && $urandom_range(0, 1) == 0)
               q.address = key.address ^ ($urandom & ({ADDR_W{1'b1}} >> $urandom_range(8, 32)));
            else
               q.address = $urandom;
         end
      end else begin
         q.func = FUNC_LOOKUP;
         q.prefix_len = 6'($urandom);
         q.family = ($urandom_range(0, 14) == 0) ? 24'($urandom) : gen_family;
         if (have_key && $urandom_range(0, 9) < 7) begin
            ep = (key.prefix_len > MAX_PREFIX) ? int'(MAX_PREFIX) : int'(key.prefix_len);
            q.address = key.address ^ ($urandom & ({ADDR_W{1'b1}} >> ep));
            if ($urandom_range(0, 4) == 0) begin
               flip = $urandom_range(0, ADDR_W - 1);
               q.address[flip] = ~q.address[flip];
            end
            case ($urandom_range(0, 3))
               0:       q.subproto = 8'($urandom);
               1:       q.subproto = SUBPROTO_WILD;
               default: q.subproto = key.subproto;
            endcase
         end else begin
            q.address = $urandom;
            q.subproto = 8'($urandom);
         end
      end
      return q;
   endfunction

   task automatic wait_idle();
      while (route_items.size() != 0 || req_tvalid || table_replies_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_family(logic [FAMILY_W-1:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      gen_family = value;
   endtask

   task automatic run_random(int n);
      for (int i = 0; i < n; i++) push_item(random_item());
   endtask

   // sender: bursts of items separated by random gaps
   always @(posedge clock) begin : drive
      query_type next_item;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tuser <= '0;
         burst_left = 0;
         gap_left = 0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (route_items.size() > 0) begin
            next_item = route_items.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {2'b00, next_item.handle, next_item.port, next_item.prefix_len,
                          next_item.address, next_item.subproto, next_item.family};
            req_tuser <= next_item.func;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 12);
               gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 150) : 0;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: changing stall pattern plus an occasional long hold-off
   always @(posedge clock) begin : receive
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_cycles = 0;
         long_hold = 0;
         mode_left = 0;
      end else begin
         rx_cycles++;
         if (rx_cycles % 25000 == 4000) long_hold = 600;
         if (long_hold > 0) begin
            long_hold--;
            rsp_tready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               stall_mode = stall_mode_t'($urandom_range(0, 2));
               mode_left = $urandom_range(20, 300);
            end else begin
               mode_left--;
            end
            case (stall_mode)
               STALL_NONE:  rsp_tready <= 1'b1;
               STALL_SOME:  rsp_tready <= ($urandom_range(0, 1) == 0);
               STALL_HEAVY: rsp_tready <= ($urandom_range(0, 3) == 0);
               default:     rsp_tready <= 1'b1;
            endcase
         end
      end
   end

   // track register writes and accepted items, check every result
   always @(posedge clock) begin : monitor
      table_reply_t got;
      table_reply_t want;
      query_type    taken;
      if (reset) begin
         foreach (tbl_valid[k]) tbl_valid[k] = 1'b0;
         tbl_count = 0;
         model_family = FAMILY_RESET;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tuser, rsp_tdata[5:0], rsp_tdata[21:6], rsp_tdata[27:22]};
            if (table_replies_due.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result, expected none, actual 0x%0h", $time, got);
            end else begin
               want = table_replies_due.pop_front();
               check_field("status", want.status, got.status);
               check_field("slot", want.slot, got.slot);
               check_field("found_handle", want.handle, got.handle);
               check_field("found_prefix", want.prefix, got.prefix);
            end
         end
         if (csr_valid && csr_ready) model_family = csr_data;
         if (req_tvalid && req_tready) begin
            taken.func = req_tuser[0];
            taken.family = req_tdata[23:0];
            taken.subproto = req_tdata[31:24];
            taken.address = req_tdata[63:32];
            taken.prefix_len = req_tdata[69:64];
            taken.port = req_tdata[85:70];
            taken.handle = req_tdata[101:86];
            table_replies_due.push_back(bind_or_lookup(taken));
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, wildcard, rebind, long prefix, foreign family, ties
      push_item('{FUNC_LOOKUP, 24'd1, 8'h00, 32'h0000_0000, 6'd0, 16'h0000, 16'h0000});
      push_item('{FUNC_BIND, 24'd1, 8'h00, 32'h0000_0000, 6'd0, 16'h0000, 16'h0000});
      push_item('{FUNC_LOOKUP, 24'd1, 8'hFF, 32'hFFFF_FFFF, 6'd0, 16'hFFFF, 16'hFFFF});
      push_item('{FUNC_BIND, 24'd1, 8'd6, 32'hC0A8_0100, 6'd24, 16'd80, 16'h1111});
      push_item('{FUNC_BIND, 24'd1, 8'd6, 32'hC0A8_0100, 6'd8, 16'd80, 16'hFFFF});
      push_item('{FUNC_BIND, 24'd1, 8'd17, 32'hC0A8_0101, 6'd63, 16'hFFFF, 16'h2222});
      push_item('{FUNC_LOOKUP, 24'd1, 8'd17, 32'hC0A8_0101, 6'd0, 16'h0000, 16'h0000});
      push_item('{FUNC_LOOKUP, 24'd1, 8'd6, 32'hC0A8_01FE, 6'd0, 16'h0000, 16'h0000});
      push_item('{FUNC_LOOKUP, 24'd1, 8'd99, 32'hC0A8_01FE, 6'd0, 16'h0000, 16'h0000});
      push_item('{FUNC_BIND, 24'hFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 6'd32, 16'hFFFF, 16'h3333});
      push_item('{FUNC_BIND, 24'hFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 6'd32, 16'hFFFF, 16'h3334});
      push_item('{FUNC_LOOKUP, 24'hFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 6'd0, 16'h0000, 16'h0000});
      push_item('{FUNC_BIND, 24'd1, 8'd6, 32'hC0A8_0100, 6'd24, 16'd81, 16'h4444});
      push_item('{FUNC_LOOKUP, 24'd1, 8'd6, 32'hC0A8_0155, 6'd0, 16'h0000, 16'h0000});
      push_item('{FUNC_BIND, 24'd1, 8'd6, 32'h0000_0000, 6'd0, 16'h0000, 16'h5555});
      push_item('{FUNC_BIND, 24'd1, 8'h00, 32'h0A00_0000, 6'd32, 16'h0000, 16'h6666});
      push_item('{FUNC_LOOKUP, 24'd1, 8'h00, 32'h0A00_0000, 6'd0, 16'h0000, 16'h0000});
      push_item('{FUNC_LOOKUP, 24'd1, 8'h00, 32'h0A00_0001, 6'd0, 16'h0000, 16'h0000});
      push_item('{FUNC_BIND, 24'd1, 8'h00, 32'h8000_0000, 6'd1, 16'h0000, 16'h7777});
      push_item('{FUNC_LOOKUP, 24'd1, 8'd5, 32'hFFFF_FFFF, 6'd0, 16'h0000, 16'h0000});
      push_item('{FUNC_BIND, 24'h00_0000, 8'hFF, 32'h0000_0000, 6'h3F, 16'hFFFF, 16'hFFFF});
      push_item('{FUNC_LOOKUP, 24'd1, 8'd17, 32'hC0A8_0100, 6'd0, 16'h0000, 16'h0000});

      // random phases; each register write waits for the block to drain
      run_random(330);
      write_family(24'hFF_FFFF);
      run_random(330);
      write_family(24'h00_0000);
      run_random(120);
      write_family(24'($urandom));
      run_random(120);
      write_family(FAMILY_RESET);
      run_random(700);

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #10ms;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
